@@ rtl/iesm_pkg.sv @@
// Shared types, constants and lookup functions for the IO event latency statistics monitor.
package iesm_pkg;

  // Default sizes of the count tables
  localparam int NUM_TYPES_DEF   = 6;
  localparam int NUM_BUCKETS_DEF = 11;

  // Field widths
  localparam int TYPE_W  = 3;
  localparam int BYTE_W  = 32;
  localparam int LAT_W   = 32;
  localparam int IDX_W   = 4;
  localparam int DATA_W  = 64;
  localparam int CFG_W   = 16;
  localparam int MULT_K_W = 10;
  localparam int PROD_W  = DATA_W + MULT_K_W;
  localparam int MID_W   = 20;

  // Event type codes
  localparam logic [TYPE_W-1:0] TYPE_READ  = 3'd0;
  localparam logic [TYPE_W-1:0] TYPE_WRITE = 3'd1;
  localparam logic [TYPE_W-1:0] TYPE_ERROR = 3'd5;

  localparam logic [CFG_W-1:0] INTERVAL_RESET = 16'd500;

  localparam int BOUND_COUNT = 10;
  localparam int PCT_COUNT   = 4;
  localparam logic [MULT_K_W-1:0] MUL_ONE      = 10'd1;
  localparam logic [MULT_K_W-1:0] MUL_THOUSAND = 10'd1000;

  // Snapshot word indexes
  localparam int WORD_ID     = 0;
  localparam int WORD_EVENTS = 1;
  localparam int WORD_BYTES  = 2;
  localparam int WORD_ERRORS = 3;
  localparam int WORD_PCT0   = 4;
  localparam int WORD_PEAK   = 8;
  localparam int WORD_TYPE0  = 9;

  // Counter slots held after the type and bucket counts
  localparam int SLOT_EVENTS = 0;
  localparam int SLOT_BYTES  = 1;
  localparam int SLOT_ERRORS = 2;
  localparam int SLOT_SNAP   = 3;
  localparam int SLOT_COUNT  = 4;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_UPD_RD,
    ST_UPD_EX,
    ST_UPD_WR,
    ST_SUM_RD,
    ST_SUM_EX,
    ST_SUM_WB,
    ST_TGT_EX,
    ST_TGT_WB,
    ST_WALK_RD,
    ST_WALK_EX,
    ST_WALK_WB,
    ST_WALK_MUL,
    ST_WALK_CMP,
    ST_OUT_RD,
    ST_OUT_LD,
    ST_OUT_SHOW,
    ST_SNP_RD,
    ST_SNP_EX,
    ST_SNP_WR
  } state_t;

  // Counter updates made for each event, in order
  typedef enum logic [2:0] {
    OP_TYPE,
    OP_BUCKET,
    OP_EVENTS,
    OP_BYTES,
    OP_ERRORS
  } upd_op_t;

  // Request to the shared multiply-add unit: res = a * k + c
  typedef struct packed {
    logic                en;
    logic [DATA_W-1:0]   a;
    logic [MULT_K_W-1:0] k;
    logic [DATA_W-1:0]   c;
  } mac_req_t;

  // Upper bound of each latency bucket in microseconds
  function automatic logic [LAT_W-1:0] bucket_bound(input logic [3:0] idx);
    logic [LAT_W-1:0] b;
    case (idx)
      4'd0:    b = 32'd10;
      4'd1:    b = 32'd50;
      4'd2:    b = 32'd100;
      4'd3:    b = 32'd500;
      4'd4:    b = 32'd1000;
      4'd5:    b = 32'd5000;
      4'd6:    b = 32'd10000;
      4'd7:    b = 32'd50000;
      4'd8:    b = 32'd100000;
      4'd9:    b = 32'd500000;
      default: b = 32'd0;
    endcase
    return b;
  endfunction

  // Midpoint reported for each bucket; beyond the table a fixed ceiling
  function automatic logic [MID_W-1:0] bucket_mid(input logic [3:0] idx);
    logic [MID_W-1:0] m;
    case (idx)
      4'd0:    m = 20'd5;
      4'd1:    m = 20'd30;
      4'd2:    m = 20'd75;
      4'd3:    m = 20'd300;
      4'd4:    m = 20'd750;
      4'd5:    m = 20'd3000;
      4'd6:    m = 20'd7500;
      4'd7:    m = 20'd30000;
      4'd8:    m = 20'd75000;
      4'd9:    m = 20'd300000;
      4'd10:   m = 20'd750000;
      default: m = 20'd1000000;
    endcase
    return m;
  endfunction

  // Percentile points in permille: p50, p95, p99, p99.9
  function automatic logic [MULT_K_W-1:0] pct_permille(input logic [1:0] idx);
    logic [MULT_K_W-1:0] p;
    case (idx)
      2'd0:    p = 10'd500;
      2'd1:    p = 10'd950;
      2'd2:    p = 10'd990;
      default: p = 10'd999;
    endcase
    return p;
  endfunction

endpackage

@@ rtl/iesm_if.sv @@
// Valid/ready channel interfaces for event input and snapshot word output.
interface iesm_in_if import iesm_pkg::*;;
  logic              valid;
  logic              ready;
  logic [TYPE_W-1:0] event_type;
  logic [BYTE_W-1:0] byte_count;
  logic [LAT_W-1:0]  event_latency;

  modport source (output valid, output event_type, output byte_count, output event_latency,
                  input ready);
  modport sink   (input valid, input event_type, input byte_count, input event_latency,
                  output ready);
endinterface

interface iesm_out_if import iesm_pkg::*;;
  logic              valid;
  logic              ready;
  logic [IDX_W-1:0]  word_index;
  logic [DATA_W-1:0] word_value;
  logic              last_word;

  modport source (output valid, output word_index, output word_value, output last_word,
                  input ready);
  modport sink   (input valid, input word_index, input word_value, input last_word,
                  output ready);
endinterface

@@ rtl/iesm_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module iesm_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 32,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/iesm_mac.sv @@
// Shared multiply-add unit: 64 x 10 bit product plus a 64 bit addend, registered result.
module iesm_mac import iesm_pkg::*; (
  input  logic              clk,
  input  mac_req_t          req,
  output logic [PROD_W-1:0] res
);

  logic [PROD_W-1:0] prod;
  logic [PROD_W-1:0] sum;
  logic [PROD_W-1:0] res_r;

  // k is 1 for plain additions, a permille or 1000 for the percentile compares
  assign prod = PROD_W'(req.a) * PROD_W'(req.k);
  assign sum  = prod + PROD_W'(req.c);

  always_ff @(posedge clk) begin
    if (req.en) begin
      res_r <= sum;
    end
  end

  assign res = res_r;

endmodule

@@ rtl/iesm_seq.sv @@
// Sequencer: event counting, histogram walk for percentiles and snapshot word output.
module iesm_seq import iesm_pkg::*; #(
  parameter int NUM_TYPES   = NUM_TYPES_DEF,
  parameter int NUM_BUCKETS = NUM_BUCKETS_DEF,
  localparam int AW = $clog2(NUM_TYPES + NUM_BUCKETS + SLOT_COUNT)
) (
  input  logic              clk,
  input  logic              rst_n,
  iesm_in_if.sink           in_ch,
  iesm_out_if.source        out_ch,
  input  logic              cfg_wr_en,
  input  logic [CFG_W-1:0]  cfg_wr_data,
  // counter RAM
  output logic              ram_we,
  output logic [AW-1:0]     ram_waddr,
  output logic [DATA_W-1:0] ram_wdata,
  output logic [AW-1:0]     ram_raddr,
  input  logic [DATA_W-1:0] ram_rdata,
  // shared multiply-add unit
  output mac_req_t          mac_req,
  input  logic [PROD_W-1:0] mac_res
);

  localparam int DEPTH      = NUM_TYPES + NUM_BUCKETS + SLOT_COUNT;
  localparam int BW         = $clog2(NUM_BUCKETS);
  localparam int SNAP_WORDS = WORD_TYPE0 + NUM_TYPES;
  localparam int WW         = $clog2(SNAP_WORDS);
  localparam logic [AW-1:0] BKT_BASE    = AW'(NUM_TYPES);
  localparam logic [AW-1:0] ADDR_EVENTS = AW'(NUM_TYPES + NUM_BUCKETS + SLOT_EVENTS);
  localparam logic [AW-1:0] ADDR_BYTES  = AW'(NUM_TYPES + NUM_BUCKETS + SLOT_BYTES);
  localparam logic [AW-1:0] ADDR_ERRORS = AW'(NUM_TYPES + NUM_BUCKETS + SLOT_ERRORS);
  localparam logic [AW-1:0] ADDR_SNAP   = AW'(NUM_TYPES + NUM_BUCKETS + SLOT_SNAP);

  state_t              state_r, state_nxt;
  upd_op_t             op_r;
  logic [TYPE_W-1:0]   ty_r;
  logic [BYTE_W-1:0]   bytes_r;
  logic [BW-1:0]       bkt_r, bkt_pick;
  logic                fire_r;
  logic [LAT_W-1:0]    peak_r;
  logic [CFG_W-1:0]    since_r, interval_r;
  logic [DATA_W-1:0]   acc_r, cum_r, out_value_r;
  logic [PROD_W-1:0]   tgt_r [PCT_COUNT];
  logic [MID_W-1:0]    pct_r [PCT_COUNT];
  logic [BW-1:0]       bi_r;
  logic [1:0]          tj_r;
  logic [2:0]          found_r;
  logic [WW-1:0]       word_r;
  logic [DEPTH-1:0]    valid_r;
  logic                rd_valid_r;

  logic [DATA_W-1:0]   rd_val;
  logic                accept, op_en, last_op, last_bkt, last_word, cmp_hit, ty_known;
  logic [AW-1:0]       op_addr, word_addr, bkt_addr;
  logic [DATA_W-1:0]   op_addend, word_value;
  logic [CFG_W:0]      since_inc, interval_eff;
  state_t              after_upd;

  assign accept    = in_ch.valid && in_ch.ready;
  assign rd_val    = rd_valid_r ? ram_rdata : '0;
  assign last_op   = (op_r == OP_ERRORS);
  assign last_bkt  = (bi_r == BW'(NUM_BUCKETS - 1));
  assign last_word = (word_r == WW'(SNAP_WORDS - 1));
  assign cmp_hit   = (mac_res >= tgt_r[found_r[1:0]]);
  assign ty_known  = (5'(ty_r) < 5'(NUM_TYPES));
  assign bkt_addr  = BKT_BASE + AW'(bi_r);
  assign after_upd = fire_r ? ST_SUM_RD : ST_IDLE;

  // Snapshot phase counter; an interval of zero acts as one
  assign interval_eff = (interval_r == '0) ? (CFG_W+1)'(1) : {1'b0, interval_r};
  assign since_inc    = {1'b0, since_r} + (CFG_W+1)'(1);

  // Latency bucket: first bound at or above the latency, else the last bucket
  always_comb begin
    bkt_pick = BW'(NUM_BUCKETS - 1);
    for (int k = NUM_BUCKETS - 2; k >= 0; k--) begin
      if (k < BOUND_COUNT && in_ch.event_latency <= bucket_bound(4'(k))) begin
        bkt_pick = BW'(k);
      end
    end
  end

  // Per-event counter update: which counter, whether it applies, what to add
  always_comb begin
    op_en     = 1'b1;
    op_addr   = ADDR_EVENTS;
    op_addend = DATA_W'(1);
    case (op_r)
      OP_TYPE: begin
        op_en   = ty_known;
        op_addr = AW'(ty_r);
      end
      OP_BUCKET: begin
        op_addr = BKT_BASE + AW'(bkt_r);
      end
      OP_EVENTS: begin
        op_addr = ADDR_EVENTS;
      end
      OP_BYTES: begin
        op_en     = (ty_r == TYPE_READ) || (ty_r == TYPE_WRITE);
        op_addr   = ADDR_BYTES;
        op_addend = DATA_W'(bytes_r);
      end
      OP_ERRORS: begin
        op_en   = (ty_r == TYPE_ERROR);
        op_addr = ADDR_ERRORS;
      end
      default: op_en = 1'b0;
    endcase
  end

  // Snapshot word source
  always_comb begin
    word_addr  = AW'(word_r - WW'(WORD_TYPE0));
    word_value = rd_val;
    if (word_r == WW'(WORD_ID)) begin
      word_addr = ADDR_SNAP;
    end else if (word_r == WW'(WORD_EVENTS)) begin
      word_addr = ADDR_EVENTS;
    end else if (word_r == WW'(WORD_BYTES)) begin
      word_addr = ADDR_BYTES;
    end else if (word_r == WW'(WORD_ERRORS)) begin
      word_addr = ADDR_ERRORS;
    end else if (word_r == WW'(WORD_PEAK)) begin
      word_value = DATA_W'(peak_r);
    end else if (word_r < WW'(WORD_TYPE0)) begin
      word_value = DATA_W'(pct_r[2'(word_r - WW'(WORD_PCT0))]);
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:     if (accept) state_nxt = ST_UPD_RD;
      ST_UPD_RD: begin
        if (op_en) state_nxt = ST_UPD_EX;
        else if (last_op) state_nxt = after_upd;
      end
      ST_UPD_EX:   state_nxt = ST_UPD_WR;
      ST_UPD_WR:   state_nxt = last_op ? after_upd : ST_UPD_RD;
      ST_SUM_RD:   state_nxt = ST_SUM_EX;
      ST_SUM_EX:   state_nxt = ST_SUM_WB;
      ST_SUM_WB:   state_nxt = last_bkt ? ST_TGT_EX : ST_SUM_RD;
      ST_TGT_EX:   state_nxt = ST_TGT_WB;
      ST_TGT_WB: begin
        if (tj_r != 2'(PCT_COUNT - 1)) state_nxt = ST_TGT_EX;
        else if (acc_r == '0) state_nxt = ST_OUT_RD;
        else state_nxt = ST_WALK_RD;
      end
      ST_WALK_RD:  state_nxt = ST_WALK_EX;
      ST_WALK_EX:  state_nxt = ST_WALK_WB;
      ST_WALK_WB:  state_nxt = ST_WALK_MUL;
      ST_WALK_MUL: state_nxt = ST_WALK_CMP;
      ST_WALK_CMP: begin
        if (cmp_hit) begin
          if (found_r == 3'(PCT_COUNT - 1)) state_nxt = ST_OUT_RD;
        end else begin
          state_nxt = last_bkt ? ST_OUT_RD : ST_WALK_RD;
        end
      end
      ST_OUT_RD:   state_nxt = ST_OUT_LD;
      ST_OUT_LD:   state_nxt = ST_OUT_SHOW;
      ST_OUT_SHOW: if (out_ch.ready) state_nxt = last_word ? ST_SNP_RD : ST_OUT_RD;
      ST_SNP_RD:   state_nxt = ST_SNP_EX;
      ST_SNP_EX:   state_nxt = ST_SNP_WR;
      ST_SNP_WR:   state_nxt = ST_IDLE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  // RAM and multiply-add controls per state
  always_comb begin
    ram_raddr   = '0;
    ram_we      = 1'b0;
    ram_waddr   = op_addr;
    ram_wdata   = mac_res[DATA_W-1:0];
    mac_req     = '0;
    mac_req.k   = MUL_ONE;
    case (state_r)
      ST_UPD_RD:  ram_raddr = op_addr;
      ST_UPD_EX: begin
        mac_req.en = 1'b1;
        mac_req.a  = rd_val;
        mac_req.c  = op_addend;
      end
      ST_UPD_WR:  ram_we = 1'b1;
      ST_SUM_RD:  ram_raddr = bkt_addr;
      ST_SUM_EX: begin
        mac_req.en = 1'b1;
        mac_req.a  = rd_val;
        mac_req.c  = (bi_r == '0) ? '0 : acc_r;
      end
      ST_TGT_EX: begin
        mac_req.en = 1'b1;
        mac_req.a  = acc_r;
        mac_req.k  = pct_permille(tj_r);
      end
      ST_WALK_RD: ram_raddr = bkt_addr;
      ST_WALK_EX: begin
        mac_req.en = 1'b1;
        mac_req.a  = rd_val;
        mac_req.c  = (bi_r == '0) ? '0 : cum_r;
      end
      ST_WALK_MUL: begin
        mac_req.en = 1'b1;
        mac_req.a  = cum_r;
        mac_req.k  = MUL_THOUSAND;
      end
      ST_OUT_RD:  ram_raddr = word_addr;
      ST_SNP_RD:  ram_raddr = ADDR_SNAP;
      ST_SNP_EX: begin
        mac_req.en = 1'b1;
        mac_req.a  = rd_val;
        mac_req.c  = DATA_W'(1);
      end
      ST_SNP_WR: begin
        ram_we    = 1'b1;
        ram_waddr = ADDR_SNAP;
      end
      default: ;
    endcase
  end

  assign in_ch.ready       = (state_r == ST_IDLE);
  assign out_ch.valid      = (state_r == ST_OUT_SHOW);
  assign out_ch.word_index = word_r[IDX_W-1:0];
  assign out_ch.word_value = out_value_r;
  assign out_ch.last_word  = last_word;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Control and running state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      interval_r <= INTERVAL_RESET;
      since_r    <= '0;
      peak_r     <= '0;
      valid_r    <= '0;
      rd_valid_r <= 1'b0;
      fire_r     <= 1'b0;
      op_r       <= OP_TYPE;
      bi_r       <= '0;
      tj_r       <= '0;
      found_r    <= '0;
      word_r     <= '0;
    end else begin
      if (cfg_wr_en) interval_r <= cfg_wr_data;
      // an entry never written reads as zero
      rd_valid_r <= valid_r[ram_raddr];
      if (ram_we) valid_r[ram_waddr] <= 1'b1;
      case (state_r)
        ST_IDLE: begin
          bi_r    <= '0;
          tj_r    <= '0;
          found_r <= '0;
          word_r  <= '0;
          if (accept) begin
            fire_r  <= (since_r == '0);
            since_r <= (since_inc >= interval_eff) ? '0 : since_inc[CFG_W-1:0];
            op_r    <= OP_TYPE;
            if (in_ch.event_latency > peak_r) peak_r <= in_ch.event_latency;
          end
        end
        ST_UPD_RD: if (!op_en && !last_op) op_r <= upd_op_t'(op_r + 3'd1);
        ST_UPD_WR: if (!last_op) op_r <= upd_op_t'(op_r + 3'd1);
        ST_SUM_WB: bi_r <= last_bkt ? '0 : BW'(bi_r + 1'b1);
        ST_TGT_WB: tj_r <= tj_r + 2'd1;
        ST_WALK_CMP: begin
          if (cmp_hit) found_r <= found_r + 3'd1;
          else if (!last_bkt) bi_r <= BW'(bi_r + 1'b1);
        end
        ST_OUT_SHOW: if (out_ch.ready && !last_word) word_r <= WW'(word_r + 1'b1);
        default: ;
      endcase
    end
  end

  // Event fields and walk data
  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE) begin
      for (int j = 0; j < PCT_COUNT; j++) pct_r[j] <= '0;
      if (accept) begin
        ty_r    <= in_ch.event_type;
        bytes_r <= in_ch.byte_count;
        bkt_r   <= bkt_pick;
      end
    end
    if (state_r == ST_SUM_WB) acc_r <= mac_res[DATA_W-1:0];
    if (state_r == ST_TGT_WB) tgt_r[tj_r] <= mac_res;
    if (state_r == ST_WALK_WB) cum_r <= mac_res[DATA_W-1:0];
    if (state_r == ST_WALK_CMP && cmp_hit) pct_r[found_r[1:0]] <= bucket_mid(4'(bi_r));
    if (state_r == ST_OUT_LD) out_value_r <= word_value;
  end

  // Checks
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> !in_ch.ready)
    else $error("input taken again straight after a transfer");

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> !in_ch.ready)
    else $error("input open while a snapshot word is offered");

  a_last_closes: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.ready && out_ch.last_word) |=> !out_ch.valid)
    else $error("word offered after the final word of a snapshot");

  a_write_marks_valid: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |=> valid_r[$past(ram_waddr)])
    else $error("counter written but not marked valid");

  a_found_bound: assert property (@(posedge clk) disable iff (!rst_n)
    found_r <= 3'(PCT_COUNT))
    else $error("percentile walk ran past the last point");

endmodule

@@ rtl/io_event_latency_stats_monitor_top.sv @@
// Top level of the IO event latency statistics monitor.
//
// in_ch carries one IO event per transfer (type, byte count, latency in us). Each event
// updates the per-type counts, event/byte/error totals, peak latency and an 11-bucket
// latency histogram; counts, totals and buckets are wrapping 64-bit counters, peak 32-bit.
// out_ch carries snapshot words (index, value, last flag). A snapshot of 9 + NUM_TYPES words
// follows every event whose phase count is zero, so the first event after reset emits one;
// cfg_wr_en/cfg_wr_data set the snapshot interval (reset 500, zero acts as one).
// Counters live in one small RAM and every add and multiply goes through a single
// multiply-add unit; each read-modify-write passes a read, an execute and a write state.
// Counter updates that do not apply to an event are skipped. An event is taken only in
// idle, so the next event waits until the previous one's updates and any snapshot are done.
// A snapshot sums the histogram, forms the percentile targets, walks the cumulative counts,
// delivers each word and steps the snapshot id; in_ch.ready is low throughout.
// Reset (synchronous, rst_n low) clears every counter at once through per-entry valid bits.
// If the receiver stalls, the current word is held on out_ch and no event is taken.
module io_event_latency_stats_monitor_top import iesm_pkg::*; #(
  parameter int NUM_TYPES   = NUM_TYPES_DEF,
  parameter int NUM_BUCKETS = NUM_BUCKETS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  iesm_in_if.sink          in_ch,
  iesm_out_if.source       out_ch,
  input  logic             cfg_wr_en,
  input  logic [CFG_W-1:0] cfg_wr_data
);

  localparam int DEPTH = NUM_TYPES + NUM_BUCKETS + SLOT_COUNT;
  localparam int AW    = $clog2(DEPTH);

  logic              ram_we;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  logic [DATA_W-1:0] ram_wdata, ram_rdata;
  mac_req_t          mac_req;
  logic [PROD_W-1:0] mac_res;

  // control and walk sequencer
  iesm_seq #(
    .NUM_TYPES   (NUM_TYPES),
    .NUM_BUCKETS (NUM_BUCKETS)
  ) u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .ram_we      (ram_we),
    .ram_waddr   (ram_waddr),
    .ram_wdata   (ram_wdata),
    .ram_raddr   (ram_raddr),
    .ram_rdata   (ram_rdata),
    .mac_req     (mac_req),
    .mac_res     (mac_res)
  );

  // counter store: type counts, buckets, totals, snapshot id
  iesm_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // shared multiply-add
  iesm_mac u_mac (
    .clk (clk),
    .req (mac_req),
    .res (mac_res)
  );

endmodule
